[rtl/fmpm_pkg.sv]
// Shared types and constants for the frame MSE and PSNR meter.
package fmpm_pkg;

    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 37;
    localparam int DIVD_W     = SUM_W + 8;
    localparam int MSE_W      = 24;
    localparam int PSNR_W     = 15;
    localparam int FRAC_W     = 24;
    localparam int LOG_W      = 29;
    localparam int KPART_W    = 17;

    localparam logic [MSE_W-1:0]   PEAK_Q8  = 24'd16646400;
    localparam logic [PSNR_W-1:0]  PSNR_MAX = 15'd32767;
    // 10*log10(2) in Q.32 split into high and low 17-bit halves
    localparam logic [KPART_W-1:0] K_HI     = 17'd98641;
    localparam logic [KPART_W-1:0] K_LO     = 17'd66713;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } fmpm_job_t;

    typedef struct packed {
        logic [MSE_W-1:0]  mse;
        logic [PSNR_W-1:0] psnr;
        logic              zero;
        logic              ovf;
    } fmpm_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CLAMP,
        S_NORM,
        S_SQ,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_DONE
    } fmpm_state_t;

endpackage

[rtl/fmpm_front.sv]
// Front end: accumulates squared differences and pair count per frame.
module fmpm_front
    import fmpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic [7:0] pixel_a,
    input  logic [7:0] pixel_b,
    input  logic      frame_end,
    input  logic      q_full,
    output logic      full,
    output logic      job_push,
    output fmpm_job_t job
);

    logic [SUM_W-1:0] sum_reg, sum_next, sum_upd;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    logic             accept;
    logic             sat;
    logic [7:0]       diff;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign diff   = (pixel_a >= pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
    assign sat    = (cnt_reg >= CNT_W'(MAX_PIXELS));

    // update accumulators, drop pairs past the bound
    always_comb
    begin
        sum_upd = sum_reg;
        cnt_upd = cnt_reg;
        ovf_upd = ovf_reg | sat;
        if (!sat)
        begin
            sum_upd = sum_reg + SUM_W'({8'd0, diff} * {8'd0, diff});
            cnt_upd = cnt_reg + CNT_W'(1);
        end
    end

    // hand the frame totals to the queue on the last beat
    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        job_push  = 1'b0;
        job.sum   = sum_upd;
        job.count = cnt_upd;
        job.ovf   = ovf_upd;
        if (accept)
        begin
            if (frame_end)
            begin
                job_push = 1'b1;
                sum_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_upd;
                cnt_next = cnt_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

[rtl/fmpm_jobq.sv]
// Two-entry queue of frame totals between front and back end.
module fmpm_jobq
    import fmpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  fmpm_job_t wr_job,
    output logic      q_full,
    input  logic      rd,
    output logic      q_empty,
    output fmpm_job_t rd_job
);

    fmpm_job_t  mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_job  = mem[rp_reg];

    // advance pointers and fill count
    always_comb
    begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/fmpm_back.sv]
// Back end: per-frame division, log2 by repeated squaring, PSNR scaling.
module fmpm_back
    import fmpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  fmpm_job_t job,
    output logic      job_pop,
    input  logic      res_pop,
    output logic      res_valid,
    output fmpm_res_t res
);

    fmpm_state_t state_reg, state_next;

    logic [DIVD_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [MSE_W-1:0]  mse_reg, mse_next;
    logic [MSE_W-1:0]  v_reg, v_next;
    logic [4:0]        e_reg, e_next;
    logic [31:0]       y_reg, y_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              peak_reg, peak_next;
    logic [LOG_W-1:0]  lp_reg, lp_next;
    logic [LOG_W-1:0]  d_reg, d_next;
    logic [45:0]       plo_reg, plo_next;
    logic [45:0]       phi_reg, phi_next;
    logic [PSNR_W-1:0] psnr_reg, psnr_next;
    logic              zero_reg, zero_next;
    logic              rv_reg, rv_next;
    fmpm_res_t         res_reg, res_next;

    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [63:0]       sq;
    logic [32:0]       t;
    logic [FRAC_W-1:0] frac_step;
    logic [LOG_W-1:0]  lval;
    logic [63:0]       total;
    logic              res_load;
    logic              is_zero;

    assign trial     = {rem_reg, dq_reg[DIVD_W-1]};
    assign qbit      = (trial >= {1'b0, div_reg});
    assign sq        = y_reg * y_reg;
    assign t         = sq[63:31];
    assign frac_step = {frac_reg[FRAC_W-2:0], t[32]};
    assign lval      = {e_reg, frac_step};
    assign total     = {1'b0, phi_reg, 17'd0} + {18'd0, plo_reg};
    assign is_zero   = (dq_reg == '0);
    assign res_load  = (state_reg == S_DONE) && (!rv_reg || res_pop);
    assign job_pop   = (state_reg == S_IDLE) && !q_empty;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (!q_empty) state_next = S_DIV;
            S_DIV:    if (cnt_reg == 6'(DIVD_W - 1)) state_next = S_CLAMP;
            S_CLAMP:  state_next = is_zero ? S_DONE : S_NORM;
            S_NORM:   if (v_reg[MSE_W-1]) state_next = S_SQ;
            S_SQ:     if (cnt_reg == 6'(FRAC_W - 1)) state_next = peak_reg ? S_NORM : S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_SUM;
            S_SUM:    state_next = S_DONE;
            S_DONE:   if (res_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        dq_next   = dq_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        mse_next  = mse_reg;
        v_next    = v_reg;
        e_next    = e_reg;
        y_next    = y_reg;
        frac_next = frac_reg;
        peak_next = peak_reg;
        lp_next   = lp_reg;
        d_next    = d_reg;
        plo_next  = plo_reg;
        phi_next  = phi_reg;
        psnr_next = psnr_reg;
        zero_next = zero_reg;
        rv_next   = rv_reg && !res_pop;
        res_next  = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                dq_next  = {job.sum, 8'd0};
                div_next = job.count;
                ovf_next = job.ovf;
                rem_next = '0;
                cnt_next = '0;
            end
            S_DIV:
            begin
                // one restoring step per cycle
                rem_next = qbit ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
                dq_next  = {dq_reg[DIVD_W-2:0], qbit};
                cnt_next = cnt_reg + 6'd1;
            end
            S_CLAMP:
            begin
                mse_next  = (dq_reg > DIVD_W'(PEAK_Q8)) ? PEAK_Q8 : dq_reg[MSE_W-1:0];
                zero_next = is_zero;
                psnr_next = PSNR_MAX;
                v_next    = PEAK_Q8;
                e_next    = 5'(MSE_W - 1);
                peak_next = 1'b1;
            end
            S_NORM:
            begin
                // shift the leading one up to the top bit
                if (v_reg[MSE_W-1])
                begin
                    y_next    = {v_reg, 8'd0};
                    frac_next = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    v_next = {v_reg[MSE_W-2:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            S_SQ:
            begin
                // square, take one fraction bit, renormalize
                frac_next = frac_step;
                y_next    = t[32] ? t[32:1] : t[31:0];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(FRAC_W - 1))
                begin
                    if (peak_reg)
                    begin
                        lp_next   = lval;
                        v_next    = mse_reg;
                        e_next    = 5'(MSE_W - 1);
                        peak_next = 1'b0;
                    end
                    else
                    begin
                        d_next = (lp_reg > lval) ? (lp_reg - lval) : '0;
                    end
                end
            end
            S_MUL_LO: plo_next = 46'(d_reg * K_LO);
            S_MUL_HI: phi_next = 46'(d_reg * K_HI);
            S_SUM:    psnr_next = total[62:48];
            S_DONE:
            begin
                if (res_load)
                begin
                    rv_next       = 1'b1;
                    res_next.mse  = mse_reg;
                    res_next.psnr = psnr_reg;
                    res_next.zero = zero_reg;
                    res_next.ovf  = ovf_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
        mse_reg  <= mse_next;
        v_reg    <= v_next;
        e_reg    <= e_next;
        y_reg    <= y_next;
        frac_reg <= frac_next;
        peak_reg <= peak_next;
        lp_reg   <= lp_next;
        d_reg    <= d_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        psnr_reg <= psnr_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !rv_reg) |=> rv_reg)
        else $error("finished frame not loaded into result register");
    a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !res_pop) |=> (rv_reg && $stable(res_reg)))
        else $error("waiting result changed");
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && res_reg.zero) |-> (res_reg.psnr == PSNR_MAX && res_reg.mse == '0))
        else $error("zero error without saturated psnr");
    a_nonzero_mse: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !res_reg.zero) |-> (res_reg.mse != '0))
        else $error("zero mse not flagged");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg == S_DIV))
        else $error("job taken without starting division");
`endif

endmodule

[rtl/frame_mse_psnr_meter_top.sv]
// Top level of the frame MSE and PSNR meter.
//
// channel  | handshake        | beat
// ---------+------------------+------------------------------------------
// input    | push / full      | pixel_a, pixel_b, frame_end
// result   | pop / empty      | mse_q16_8, psnr_q8_8, zero_error, count_overflow
//
// Pixel pairs go in one per cycle while full is low; full rises only while two
// finished frames wait. Per frame: job take, divide, clamp, peak log2, MSE log2,
// multiply and load; a zero MSE goes from clamp straight to load.
// rst_n clears accumulators, queue and result valid asynchronously.
// A result waits in the output register while the back end starts the next frame.
module frame_mse_psnr_meter_top
    import fmpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        pixel_a,
    input  logic [7:0]        pixel_b,
    input  logic              frame_end,
    output logic              empty,
    input  logic              pop,
    output logic [MSE_W-1:0]  mse_q16_8,
    output logic [PSNR_W-1:0] psnr_q8_8,
    output logic              zero_error,
    output logic              count_overflow
);

    fmpm_job_t job_in, job_out;
    fmpm_res_t res;
    logic      job_push, job_pop, q_full, q_empty, res_valid;

    fmpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pixel_a   (pixel_a),
        .pixel_b   (pixel_b),
        .frame_end (frame_end),
        .q_full    (q_full),
        .full      (full),
        .job_push  (job_push),
        .job       (job_in)
    );

    fmpm_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_job  (job_in),
        .q_full  (q_full),
        .rd      (job_pop),
        .q_empty (q_empty),
        .rd_job  (job_out)
    );

    fmpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_pop   (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty          = !res_valid;
    assign mse_q16_8      = res.mse;
    assign psnr_q8_8      = res.psnr;
    assign zero_error     = res.zero;
    assign count_overflow = res.ovf;

endmodule
